FILE: src/barycentric_weights_2d_defines.svh
// Assertion macros for the barycentric weight block
`ifndef BARYCENTRIC_WEIGHTS_2D_DEFINES_SVH
`define BARYCENTRIC_WEIGHTS_2D_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("barycentric weights: implication check failed");

// next-cycle implication, checked out of reset
`define BW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("barycentric weights: next-cycle check failed");

`endif

FILE: src/bw_pkg.sv
// Shared widths, types and constants of the barycentric weight block
`timescale 1ns / 1ps
package bw_pkg;
    localparam int COORD_W = 16;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int NUM_W   = CROSS_W + 2;
    localparam int DEN_W   = CROSS_W;
    localparam int FRAC_SH = 15;
    localparam int QUO_W   = 17;
    localparam int REM_W   = NUM_W + FRAC_SH;
    localparam int LANES   = 3;
    localparam int LIMIT_W = 32;
    localparam int WEIGHT_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd429497;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_NEG_ONE = -16'sd16384;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sd32767;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -16'sd32768;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0] den_t;
    typedef logic [QUO_W-1:0] quo_t;
    typedef logic [REM_W-1:0] rem_t;

    // sideband carried alongside the divider lanes
    typedef struct packed {
        logic       degen;
        logic [2:0] neg;
    } bw_side_t;
endpackage

FILE: src/bw_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
`timescale 1ns / 1ps
module bw_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bw_pkg::num_t      in_num [bw_pkg::LANES],
    input  bw_pkg::den_t      in_den,
    input  bw_pkg::bw_side_t  in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output bw_pkg::quo_t      out_quo [bw_pkg::LANES],
    output bw_pkg::bw_side_t  out_side
);
    import bw_pkg::*;

    localparam int STG = QUO_W + 1;

    logic     vld_reg  [STG];
    logic     en       [STG];
    rem_t     rem_reg  [STG][LANES];
    quo_t     quo_reg  [STG][LANES];
    logic     ovf_reg  [STG][LANES];
    den_t     den_reg  [STG];
    bw_side_t side_reg [STG];

    rem_t     rem_next [STG][LANES];
    logic     qbit     [STG][LANES];

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        en[STG-1] = !vld_reg[STG-1] || out_ready;
        for (int k = STG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end
    assign in_ready = en[0];

    always_comb begin
        logic [REM_W:0] diff;
        diff = '0;
        for (int l = 0; l < LANES; l++) begin
            rem_next[0][l] = {in_num[l], FRAC_SH'(0)};
            qbit[0][l]     = 1'b0;
        end
        for (int k = 1; k < STG; k++) begin
            for (int l = 0; l < LANES; l++) begin
                diff = {1'b0, rem_reg[k-1][l]}
                     - ((REM_W + 1)'(den_reg[k-1]) << (QUO_W - k));
                qbit[k][l]     = !diff[REM_W];
                rem_next[k][l] = diff[REM_W] ? rem_reg[k-1][l] : diff[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STG; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < STG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= rem_next[0][l];
                quo_reg[0][l] <= '0;
                // quotient would not fit in QUO_W bits
                ovf_reg[0][l] <= in_num[l] >= {in_den, 2'b00};
            end
        end
        for (int k = 1; k < STG; k++) begin
            if (en[k]) begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= rem_next[k][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                    quo_reg[k][l] <= quo_reg[k-1][l]
                                   | (QUO_W'(qbit[k][l]) << (QUO_W - k));
                end
            end
        end
    end

    assign out_valid = vld_reg[STG-1];
    assign out_side  = side_reg[STG-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quo[l] = ovf_reg[STG-1][l] ? '1 : quo_reg[STG-1][l];
        end
    end
endmodule

FILE: src/barycentric_weights_2d.sv
// Barycentric weights of a point in a 2D triangle, Q8.8 in, Q2.14 out
// Throughput: one request per cycle while m_tready does not stall the output; the
// 18-stage divider (a load stage, then one quotient bit per stage, three lanes) sets
// the depth, every stage takes a new request.
// Stages load whenever empty, so bubbles close up under output stall.
// Reset (aresetn low, synchronous) empties the pipeline and sets the limit to 429497.
`timescale 1ns / 1ps
module barycentric_weights_2d (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // weight_u, weight_v, weight_w
    output logic [47:0]  m_tdata,
    // degenerate, inside_res
    output logic [1:0]   m_tuser
);
    import bw_pkg::*;

    `include "barycentric_weights_2d_defines.svh"

    localparam int NST = 6;

    logic [LIMIT_W-1:0] limit_reg;
    logic               vld_reg [NST];
    logic               en      [NST];
    logic               out_en;
    logic               div_in_ready;
    logic               div_out_valid;
    quo_t               div_quo [LANES];
    bw_side_t           div_side;

    logic signed [COORD_W-1:0] crd [8];

    logic signed [EDGE_W-1:0]  e_reg [6];   // e0x e0y e1x e1y e2x e2y
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] c3_reg, nv3_reg, nw3_reg;
    logic signed [CROSS_W-1:0] c4_reg, nv4_reg, nw4_reg;
    logic signed [NUM_W-1:0]   nu4_reg;
    den_t                      cm4_reg;
    den_t                      cm5_reg;
    logic [LIMIT_W-1:0]        sq5_reg;
    num_t                      mag5_reg [LANES];
    logic [2:0]                neg5_reg;
    num_t                      mag6_reg [LANES];
    den_t                      den6_reg;
    bw_side_t                  side6_reg;

    logic                      m_valid_reg;
    logic [47:0]               m_data_reg;
    logic [1:0]                m_user_reg;

    logic [47:0]               out_data_next;
    logic [1:0]                out_user_next;
    logic signed [WEIGHT_W-1:0] wgt [LANES];

    function automatic logic signed [WEIGHT_W-1:0] round_sat(quo_t q0, logic neg);
        logic [QUO_W:0] q;
        q = ({1'b0, q0} + (QUO_W + 1)'(1)) >> 1;
        if (neg) begin
            round_sat = (q > (QUO_W + 1)'(32768)) ? WEIGHT_MIN : WEIGHT_W'(-q);
        end else begin
            round_sat = (q > (QUO_W + 1)'(32767)) ? WEIGHT_MAX : WEIGHT_W'(q);
        end
    endfunction

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            crd[i] = s_tdata[i*COORD_W +: COORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        out_en      = !m_valid_reg || m_tready;
        en[NST-1]   = !vld_reg[NST-1] || div_in_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end
    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // edge vectors from vertex 0
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            e_reg[0] <= EDGE_W'(crd[4]) - EDGE_W'(crd[2]);
            e_reg[1] <= EDGE_W'(crd[5]) - EDGE_W'(crd[3]);
            e_reg[2] <= EDGE_W'(crd[6]) - EDGE_W'(crd[2]);
            e_reg[3] <= EDGE_W'(crd[7]) - EDGE_W'(crd[3]);
            e_reg[4] <= EDGE_W'(crd[0]) - EDGE_W'(crd[2]);
            e_reg[5] <= EDGE_W'(crd[1]) - EDGE_W'(crd[3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p_reg[0] <= PROD_W'(e_reg[0]) * PROD_W'(e_reg[3]);
            p_reg[1] <= PROD_W'(e_reg[1]) * PROD_W'(e_reg[2]);
            p_reg[2] <= PROD_W'(e_reg[4]) * PROD_W'(e_reg[3]);
            p_reg[3] <= PROD_W'(e_reg[5]) * PROD_W'(e_reg[2]);
            p_reg[4] <= PROD_W'(e_reg[0]) * PROD_W'(e_reg[5]);
            p_reg[5] <= PROD_W'(e_reg[1]) * PROD_W'(e_reg[4]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            c3_reg  <= CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
            nv3_reg <= CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
            nw3_reg <= CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            c4_reg  <= c3_reg;
            nv4_reg <= nv3_reg;
            nw4_reg <= nw3_reg;
            nu4_reg <= NUM_W'(c3_reg) - NUM_W'(nv3_reg) - NUM_W'(nw3_reg);
            cm4_reg <= c3_reg[CROSS_W-1] ? DEN_W'(-c3_reg) : DEN_W'(c3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            cm5_reg     <= cm4_reg;
            sq5_reg     <= LIMIT_W'(cm4_reg[15:0]) * LIMIT_W'(cm4_reg[15:0]);
            mag5_reg[0] <= nu4_reg[NUM_W-1] ? num_t'(-nu4_reg) : num_t'(nu4_reg);
            mag5_reg[1] <= nv4_reg[CROSS_W-1] ? num_t'(-NUM_W'(nv4_reg)) : num_t'(nv4_reg);
            mag5_reg[2] <= nw4_reg[CROSS_W-1] ? num_t'(-NUM_W'(nw4_reg)) : num_t'(nw4_reg);
            neg5_reg[0] <= nu4_reg[NUM_W-1] ^ c4_reg[CROSS_W-1];
            neg5_reg[1] <= nv4_reg[CROSS_W-1] ^ c4_reg[CROSS_W-1];
            neg5_reg[2] <= nw4_reg[CROSS_W-1] ^ c4_reg[CROSS_W-1];
        end
    end

    // zero always degenerate; at 2^16 or more the square exceeds any limit
    always_ff @(posedge aclk) begin
        if (en[5]) begin
            den6_reg        <= cm5_reg;
            side6_reg.neg   <= neg5_reg;
            side6_reg.degen <= (cm5_reg == '0)
                            || ((cm5_reg[DEN_W-1:16] == '0) && (sq5_reg < limit_reg));
            for (int l = 0; l < LANES; l++) begin
                mag6_reg[l] <= mag5_reg[l];
            end
        end
    end

    bw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[NST-1]),
        .in_ready  (div_in_ready),
        .in_num    (mag6_reg),
        .in_den    (den6_reg),
        .in_side   (side6_reg),
        .out_valid (div_out_valid),
        .out_ready (out_en),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            wgt[l] = div_side.degen ? WEIGHT_NEG_ONE : round_sat(div_quo[l], div_side.neg[l]);
        end
        out_data_next = {wgt[2], wgt[1], wgt[0]};
        out_user_next[0] = div_side.degen;
        out_user_next[1] = !div_side.degen && !wgt[0][WEIGHT_W-1]
                        && !wgt[1][WEIGHT_W-1] && !wgt[2][WEIGHT_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_data_reg <= out_data_next;
            m_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `BW_ASSERT_IMPL(a_degen_weights, m_tvalid && m_tuser[0], (m_tdata[15:0] == WEIGHT_NEG_ONE) && (m_tdata[31:16] == WEIGHT_NEG_ONE) && (m_tdata[47:32] == WEIGHT_NEG_ONE) && !m_tuser[1])
    `BW_ASSERT_IMPL(a_inside_sign, m_tvalid && m_tuser[1], !m_tdata[15] && !m_tdata[31] && !m_tdata[47])
    `BW_ASSERT_IMPL(a_full_stall, !s_tready, m_tvalid && !m_tready && div_out_valid && !div_in_ready)
    `BW_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
endmodule

FILE: bench/testbench.sv
// Self-checking bench for the barycentric weight block: predicted weights vs. m_ stream
`timescale 1ns / 1ps
module testbench;
    import bw_pkg::*;

    typedef struct packed {
        logic signed [15:0] vy2, vx2, vy1, vx1, vy0, vx0, py, px;
    } tri_req_t;

    typedef struct packed {
        logic [1:0]  flags;
        logic [47:0] weights;
    } weight_res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [31:0] cfg_wr_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [127:0] s_tdata = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic [1:0] m_tuser;

    barycentric_weights_2d dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    logic [31:0] limit_q = LIMIT_RESET;
    tri_req_t pending_reqs[$];
    weight_res_t expected_weights[$];
    int mismatches = 0;
    int hold_cycles = 0;
    bit sender_paused = 0;

    function automatic logic signed [15:0] round_q14(longint num, longint den);
        longint unsigned n, d, q;
        bit neg;
        n = (num < 0 ? -num : num) << 14;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        neg = (num < 0) != (den < 0);
        if (neg) return (q > 32768) ? WEIGHT_MIN : 16'(-longint'(q));
        return (q > 32767) ? WEIGHT_MAX : 16'(q);
    endfunction

    function automatic weight_res_t predict_weights(tri_req_t r);
        longint e0x, e0y, e1x, e1y, e2x, e2y, c, nv, nw, cm;
        logic signed [15:0] u, v, w;
        bit degen;
        weight_res_t res;
        e0x = r.vx1 - r.vx0; e0y = r.vy1 - r.vy0;
        e1x = r.vx2 - r.vx0; e1y = r.vy2 - r.vy0;
        e2x = r.px - r.vx0;  e2y = r.py - r.vy0;
        c = e0x * e1y - e0y * e1x;
        cm = c < 0 ? -c : c;
        if (cm == 0) degen = 1;
        else if (cm >= 65536) degen = 0;
        else degen = (cm * cm) < longint'(limit_q);
        if (degen) begin
            u = WEIGHT_NEG_ONE; v = WEIGHT_NEG_ONE; w = WEIGHT_NEG_ONE;
        end else begin
            nv = e2x * e1y - e2y * e1x;
            nw = e0x * e2y - e0y * e2x;
            u = round_q14(c - nv - nw, c);
            v = round_q14(nv, c);
            w = round_q14(nw, c);
        end
        res.weights = {w, v, u};
        res.flags = {!degen && u >= 0 && v >= 0 && w >= 0, degen};
        return res;
    endfunction

    task automatic add_req(tri_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    bit s_tready_seen = 0;
    bit m_taken = 0;
    int m_draw = 0;

    // driver: hold each request until accepted, then idle for its drawn gap
    int s_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (s_gap > 0) begin
                    s_tvalid <= 0;
                    s_gap <= s_gap - 1;
                end else if (pending_reqs.size() > 0 && !sender_paused) begin
                    s_tdata <= pending_reqs.pop_front();
                    s_tvalid <= 1;
                    s_gap <= $urandom_range(0, 4);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        s_tready_seen <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_weights.insert(expected_weights.size(), predict_weights(s_tdata));
    end

    // receiver: random stall per result, long hold-off when requested
    int m_gap = 0;
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else if (m_taken) begin
            m_draw = $urandom_range(0, 4);
            m_gap <= (m_draw > 0) ? m_draw - 1 : 0;
            m_tready <= (m_draw == 0);
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        weight_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %b", m_tdata, m_tuser);
            end else begin
                want = expected_weights.pop_front();
                if (want.weights !== m_tdata || want.flags !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected u=%h v=%h w=%h f=%b, got u=%h v=%h w=%h f=%b",
                            want.weights[15:0], want.weights[31:16], want.weights[47:32],
                            want.flags, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser);
                end
            end
        end
    end

    function automatic tri_req_t random_tri(int spread);
        tri_req_t r;
        int cx, cy, k;
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        k = $urandom_range(0, 7);
        if (k < 2) r = {$urandom, $urandom, $urandom, $urandom};
        else begin
            r.px  = 16'(cx + $urandom_range(0, 2 * spread) - spread);
            r.py  = 16'(cy + $urandom_range(0, 2 * spread) - spread);
            r.vx0 = 16'(cx + $urandom_range(0, 2 * spread) - spread);
            r.vy0 = 16'(cy + $urandom_range(0, 2 * spread) - spread);
            r.vx1 = 16'(cx + $urandom_range(0, 2 * spread) - spread);
            r.vy1 = 16'(cy + $urandom_range(0, 2 * spread) - spread);
            r.vx2 = 16'(cx + $urandom_range(0, 2 * spread) - spread);
            r.vy2 = 16'(cy + $urandom_range(0, 2 * spread) - spread);
            // collinear vertex now and then
            if (k == 7) begin
                r.vx2 = 16'(2 * r.vx1 - r.vx0);
                r.vy2 = 16'(2 * r.vy1 - r.vy0);
            end
        end
        return r;
    endfunction

    task automatic drain_and_write(logic [31:0] val);
        while (pending_reqs.size() > 0 || s_tvalid || expected_weights.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= val;
        limit_q = val;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    initial begin
        logic [31:0] limits[4];
        limits = '{32'd0, 32'hFFFFFFFF, 32'd65536, 32'd429497};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: unit triangle, extremes, degenerate, tiny area
        add_req({16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd64, 16'sd64});
        add_req({16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                 16'sh7FFF, 16'sh8000});
        add_req({16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF});
        add_req({16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                 16'sh8000, 16'sh8000, 16'sh0, 16'sh0});
        add_req({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5});
        add_req({16'sd0, 16'sd2, 16'sd0, 16'sd4, 16'sd0, 16'sd0, 16'sd1, 16'sd1});
        add_req({16'sd3, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd2});
        add_req({16'sd300, 16'sd0, 16'sd0, 16'sd300, 16'sd0, 16'sd0,
                 16'sd100, 16'sd100});
        add_req({16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0,
                 -16'sd1, 16'sd128});
        for (int i = 0; i < 8; i++) add_req(random_tri(4));
        // long receiver hold-off while requests keep coming
        for (int i = 0; i < 60; i++) add_req(random_tri(2000));
        hold_cycles = 120;
        for (int phase = 0; phase < 4; phase++) begin
            drain_and_write(limits[phase]);
            for (int i = 0; i < 240; i++)
                add_req(random_tri(phase == 1 ? 200 : ($urandom_range(0, 1) ? 8 : 3000)));
            if (phase == 2) begin
                while (pending_reqs.size() > 120) @(posedge aclk);
                sender_paused = 1;
                while (s_tvalid || expected_weights.size() > 0) @(posedge aclk);
                sender_paused = 0;
            end
        end
        while (pending_reqs.size() > 0 || s_tvalid || expected_weights.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && expected_weights.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end
endmodule
